@@ src/dtgr_pkg.sv @@
// ----------------------------------------------------------------------------
// dtgr_pkg
// Shared types and constants of the depth-tested grid resampler.
// ----------------------------------------------------------------------------
package dtgr_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int ROWS        = 180;
    localparam int MAX_GAP     = 20;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = 8;
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int CELLS       = ROWS * MAX_COLUMNS;
    localparam int NCOL_W      = COL_W + 1;
    localparam int DEPTH_W     = 16;
    localparam int LABEL_W     = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic        sample_known;
        logic [7:0]  row;
        logic [15:0] label;
        logic [15:0] eye_depth;
        logic [23:0] path_len;
        logic [11:0] read_column;
    } t_in;

    typedef struct packed {
        logic [15:0] cell_label;
        logic        cell_known;
        logic        fill_done;
    } t_out;

endpackage

@@ src/dtgr_ram.sv @@
// ----------------------------------------------------------------------------
// dtgr_ram
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module dtgr_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/dtgr_colmap.sv @@
// ----------------------------------------------------------------------------
// dtgr_colmap
// Maps a travel distance to a column: registered product, then rounding.
// ----------------------------------------------------------------------------
module dtgr_colmap (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [23:0] i_travel,
    input  logic [31:0] i_scale,
    output logic [24:0] o_column
);
    logic [55:0] r_prod;
    logic [56:0] rounded;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= 56'(i_travel) * 56'(i_scale);
        end
    end

    assign rounded  = {1'b0, r_prod} + 57'h0_0000_0080_0000_00;
    assign o_column = rounded[56:32];
endmodule

@@ src/depth_tested_grid_resample_top.sv @@
// ----------------------------------------------------------------------------
// depth_tested_grid_resample_top
// Depth-tested scatter into an angle-by-distance grid, with gap fill.
//
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   i_in (t_in)
// result    out        o_valid, one cycle     o_res (t_out)
// config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// An insert steps through a multiply, a column check with depth read,
// then compare and write.
// An in-range read waits in S_RD_WAIT, one out of range answers from idle;
// a clear sweeps all CELLS addresses of both memories, as does the clearing pass after reset.
// A fill reads and checks each row scanned in each column; across a gap it
// reads the left and right cells of each row and writes every filled cell.
// Results cannot be stalled; busy stays high until an item is finished.
// ----------------------------------------------------------------------------
module depth_tested_grid_resample_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dtgr_pkg::t_in  i_in,
    output logic           o_valid,
    output dtgr_pkg::t_out o_res,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [31:0]    i_cfg_data
);
    import dtgr_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_CLR     = 13'b0000000000010,
        S_INS_ADR = 13'b0000000000100,
        S_INS_CMP = 13'b0000000001000,
        S_RD_WAIT = 13'b0000000010000,
        S_F_SRD   = 13'b0000000100000,
        S_F_SCHK  = 13'b0000001000000,
        S_F_LRD   = 13'b0000010000000,
        S_F_LCHK  = 13'b0000100000000,
        S_F_RRD   = 13'b0001000000000,
        S_F_RCHK  = 13'b0010000000000,
        S_F_WR    = 13'b0100000000000,
        S_F_END   = 13'b1000000000000
    } t_state;

    t_state              r_state, n_state;
    logic [12:0]         r_col_count;
    logic [31:0]         r_scale;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [LABEL_W-1:0]  r_label, n_label;
    logic [DEPTH_W-1:0]  r_depth;
    logic                r_known;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [NCOL_W-1:0]   r_right, n_right;
    logic [COL_W-1:0]    r_left, n_left;
    logic                r_have_left, n_have_left;
    logic [NCOL_W-1:0]   r_col, n_col;
    logic                r_valid, n_valid;
    t_out                r_res, n_res;

    logic [NCOL_W-1:0]   ncol;
    logic [24:0]         column;
    logic                accept;
    logic                dep_we, lab_we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [DEPTH_W-1:0]  dep_wdata, dep_rdata;
    logic [LABEL_W:0]    lab_wdata, lab_rdata;
    logic [NCOL_W-1:0]   right_inc;
    logic                gap_ok, last_row;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign ncol      = (r_col_count > 13'(MAX_COLUMNS)) ? NCOL_W'(MAX_COLUMNS)
                                                        : NCOL_W'(r_col_count);
    assign right_inc = r_right + NCOL_W'(1);
    assign last_row  = (r_row == ROW_W'(ROWS - 1));
    assign gap_ok    = r_have_left
                       && (({1'b0, r_left} + NCOL_W'(1)) < r_right)
                       && ((r_right - {1'b0, r_left}) <= NCOL_W'(MAX_GAP));

    dtgr_colmap u_colmap (
        .i_clk    (i_clk),
        .i_load   (accept),
        .i_travel (i_in.path_len),
        .i_scale  (r_scale),
        .o_column (column)
    );

    dtgr_ram #(.WIDTH(DEPTH_W), .DEPTH(CELLS), .ADDR_W(ADDR_W)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (waddr),
        .i_wdata (dep_wdata),
        .i_raddr (raddr),
        .o_rdata (dep_rdata)
    );

    dtgr_ram #(.WIDTH(LABEL_W + 1), .DEPTH(CELLS), .ADDR_W(ADDR_W)) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (lab_we),
        .i_waddr (waddr),
        .i_wdata (lab_wdata),
        .i_raddr (raddr),
        .o_rdata (lab_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_label     = r_label;
        n_addr      = r_addr;
        n_clr_addr  = r_clr_addr;
        n_right     = r_right;
        n_left      = r_left;
        n_have_left = r_have_left;
        n_col       = r_col;
        n_valid     = 1'b0;
        n_res       = '0;
        dep_we      = 1'b0;
        lab_we      = 1'b0;
        waddr       = r_addr;
        dep_wdata   = r_depth;
        lab_wdata   = {1'b1, r_label};
        raddr       = {r_row, r_right[COL_W-1:0]};
        case (r_state)
            S_IDLE: begin
                raddr = {i_in.row, i_in.read_column};
                if (accept) begin
                    n_row   = i_in.row;
                    n_label = i_in.label;
                    case (i_in.operation)
                        OP_INSERT: n_state = S_INS_ADR;
                        OP_FILL: begin
                            n_right     = '0;
                            n_row       = '0;
                            n_have_left = 1'b0;
                            n_state     = (ncol == '0) ? S_F_END : S_F_SRD;
                        end
                        OP_READ: begin
                            if (i_in.row < ROW_W'(ROWS)
                                && {1'b0, i_in.read_column} < ncol) begin
                                n_state = S_RD_WAIT;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_clr_addr = '0;
                            n_state    = S_CLR;
                        end
                    endcase
                end
            end
            S_CLR: begin
                dep_we     = 1'b1;
                lab_we     = 1'b1;
                waddr      = r_clr_addr;
                dep_wdata  = '1;
                lab_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_INS_ADR: begin
                n_addr = {r_row, column[COL_W-1:0]};
                raddr  = {r_row, column[COL_W-1:0]};
                if (r_known && r_row < ROW_W'(ROWS) && column < 25'(ncol)) begin
                    n_state = S_INS_CMP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INS_CMP: begin
                if (r_depth < dep_rdata) begin
                    dep_we = 1'b1;
                    lab_we = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_RD_WAIT: begin
                n_valid            = 1'b1;
                n_res.cell_label   = lab_rdata[LABEL_W-1:0];
                n_res.cell_known   = lab_rdata[LABEL_W];
                n_state            = S_IDLE;
            end
            S_F_SRD: begin
                n_state = S_F_SCHK;
            end
            S_F_SCHK: begin
                if (lab_rdata[LABEL_W] && gap_ok) begin
                    n_row   = '0;
                    n_state = S_F_LRD;
                end else if (lab_rdata[LABEL_W] || last_row) begin
                    if (lab_rdata[LABEL_W]) begin
                        n_left      = r_right[COL_W-1:0];
                        n_have_left = 1'b1;
                    end
                    n_right = right_inc;
                    n_row   = '0;
                    n_state = (right_inc == ncol) ? S_F_END : S_F_SRD;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = S_F_SRD;
                end
            end
            S_F_LRD: begin
                raddr   = {r_row, r_left};
                n_state = S_F_LCHK;
            end
            S_F_RRD: begin
                n_state = S_F_RCHK;
            end
            S_F_LCHK, S_F_RCHK, S_F_WR: begin
                if (r_state == S_F_WR) begin
                    lab_we    = 1'b1;
                    waddr     = {r_row, r_col[COL_W-1:0]};
                end
                if (r_state == S_F_LCHK && lab_rdata[LABEL_W]) begin
                    n_label = lab_rdata[LABEL_W-1:0];
                    n_state = S_F_RRD;
                end else if (r_state == S_F_RCHK && lab_rdata[LABEL_W]) begin
                    n_col   = {1'b0, r_left} + NCOL_W'(1);
                    n_state = S_F_WR;
                end else if (r_state == S_F_WR && r_col != r_right - NCOL_W'(1)) begin
                    n_col   = r_col + NCOL_W'(1);
                end else if (last_row) begin
                    n_left      = r_right[COL_W-1:0];
                    n_have_left = 1'b1;
                    n_right     = right_inc;
                    n_row       = '0;
                    n_state     = (right_inc == ncol) ? S_F_END : S_F_SRD;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = S_F_LRD;
                end
            end
            S_F_END: begin
                n_valid         = 1'b1;
                n_res.fill_done = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_col_count <= 13'd4096;
            r_scale     <= 32'd16777216;
            r_valid     <= 1'b0;
            r_have_left <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_valid     <= n_valid;
            r_have_left <= n_have_left;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_COUNT) begin
                    r_col_count <= i_cfg_data[12:0];
                end else begin
                    r_scale <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_label <= n_label;
        r_addr  <= n_addr;
        r_right <= n_right;
        r_left  <= n_left;
        r_col   <= n_col;
        r_res   <= n_res;
        if (accept) begin
            r_depth <= i_in.eye_depth;
            r_known <= i_in.sample_known;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_clear_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.operation == OP_CLEAR |=> r_state == S_CLR)
        else $error("clear did not start the sweep");
    a_fill_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.fill_done |-> !o_res.cell_known && o_res.cell_label == '0)
        else $error("fill result carries cell data");
    a_depth_with_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dep_we |-> lab_we)
        else $error("depth written without label");
    a_label_only_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lab_we && !dep_we |-> r_state == S_F_WR)
        else $error("label-only write outside fill");
endmodule
